// File: sv/smt_pkg.sv
// Shared types, codes and helpers for the sorted multiset table.
package smt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADD_W = 16;
  localparam int unsigned CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_MERGE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                     cmp_en;
    logic                     upd_en;
    op_e                      op;
    logic signed [DATA_W-1:0] value;
    logic [ADD_W-1:0]         add_cnt;
  } cell_ctrl_t;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

endpackage

// File: sv/smt_cell.sv
// One table slot: holds a key and its count, compares and shifts with neighbors.
module smt_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  smt_pkg::cell_ctrl_t              ctrl_i,
  input  logic                             valid_i,
  input  logic                             left_lt_i,
  input  logic signed [smt_pkg::DATA_W-1:0] left_key_i,
  input  logic [smt_pkg::DATA_W-1:0]       left_count_i,
  input  logic signed [smt_pkg::DATA_W-1:0] right_key_i,
  input  logic [smt_pkg::DATA_W-1:0]       right_count_i,
  output logic signed [smt_pkg::DATA_W-1:0] key_o,
  output logic [smt_pkg::DATA_W-1:0]       count_o,
  output logic                             lt_o,
  output logic                             eq_o
);

  logic signed [smt_pkg::DATA_W-1:0] key_q, key_d;
  logic [smt_pkg::DATA_W-1:0]        count_q, count_d;
  logic                              lt_q, eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      lt_q <= valid_i && (key_q < ctrl_i.value);
      eq_q <= valid_i && (key_q == ctrl_i.value);
    end
  end

  always_comb begin
    key_d = key_q;
    count_d = count_q;
    if (ctrl_i.upd_en) begin
      case (ctrl_i.op)
        smt_pkg::OP_MERGE: begin
          if (eq_q) begin
            count_d = smt_pkg::sat_add(count_q,
                                       {{(smt_pkg::DATA_W-smt_pkg::ADD_W){1'b0}},
                                        ctrl_i.add_cnt});
          end
        end
        smt_pkg::OP_INSERT: begin
          // slots at or above the insert point move up; the insert point takes the new key
          if (!lt_q) begin
            if (left_lt_i) begin
              key_d = ctrl_i.value;
              count_d = {{(smt_pkg::DATA_W-smt_pkg::ADD_W){1'b0}}, ctrl_i.add_cnt};
            end else begin
              key_d = left_key_i;
              count_d = left_count_i;
            end
          end
        end
        smt_pkg::OP_DELETE: begin
          if (!lt_q) begin
            key_d = right_key_i;
            count_d = right_count_i;
          end
        end
        default: begin
          key_d = key_q;
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    count_q <= count_d;
  end

  assign key_o = key_q;
  assign count_o = count_q;
  assign lt_o = lt_q;
  assign eq_o = eq_q;

endmodule

// File: sv/sorted_multiset_table_core.sv
// Top level of the sorted multiset table: command sequencer and cell chain.
// Usage:
//   A command (command_i, value_i, add_count_i) transfers at a rising edge
//   with start high and busy low. Command 0 adds add_count_i occurrences,
//   1 removes the value's entry, 2 (and 3) only query.
//   Every command gives one result, shown for exactly one cycle with
//   result_valid_o high, after the compare and update phases that follow it.
//   Compare phase: every cell compares its key with the value in parallel.
//   Update phase: cells merge, shift up (insert) or shift down (delete) in one
//   step; total and fill count update and the result is registered.
//   busy is high only during the compare cycle, so a new command can
//   transfer while the previous one updates.
//   item_total_o, smallest_value_o and set_empty_o follow the stored state
//   and are valid while result_valid_o is high.
//   Reset clears the fill count and the total: the table comes up empty.
//   The receiver cannot stall; a result not taken in its cycle is gone.
module sorted_multiset_table_core #(
  parameter int unsigned MAX_ENTRIES = smt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [smt_pkg::CMD_W-1:0]         command_i,
  input  logic signed [smt_pkg::DATA_W-1:0] value_i,
  input  logic [smt_pkg::ADD_W-1:0]         add_count_i,
  output logic                              result_valid_o,
  output logic [smt_pkg::DATA_W-1:0]        count_of_value_o,
  output logic                              value_present_o,
  output logic [smt_pkg::DATA_W-1:0]        item_total_o,
  output logic signed [smt_pkg::DATA_W-1:0] smallest_value_o,
  output logic                              set_empty_o,
  output logic                              table_full_error_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DW = smt_pkg::DATA_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_UPD  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic       accept;

  logic [smt_pkg::CMD_W-1:0]         cmd_q;
  logic signed [DW-1:0]              value_q;
  logic [smt_pkg::ADD_W-1:0]         add_q;

  logic [CNT_W-1:0] used_q, used_d;
  logic [DW-1:0]    total_q, total_d;

  logic          rvalid_q;
  logic [DW-1:0] res_cnt_q, res_cnt_d;
  logic          res_hit_q, res_hit_d;
  logic          res_full_q, res_full_d;

  smt_pkg::cell_ctrl_t ctrl;
  smt_pkg::op_e        op;

  logic signed [DW-1:0] cell_key   [MAX_ENTRIES];
  logic [DW-1:0]        cell_count [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_lt, cell_eq, cell_valid;

  logic          hit;
  logic [DW-1:0] hit_cnt;
  logic [DW-1:0] add_ext;

  assign accept = start && !busy;
  assign busy = (phase_q == PH_CMP);
  assign add_ext = {{(DW-smt_pkg::ADD_W){1'b0}}, add_q};

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: if (accept) phase_d = PH_CMP;
      PH_CMP:  phase_d = PH_UPD;
      PH_UPD:  phase_d = accept ? PH_CMP : PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      used_q <= '0;
      total_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      used_q <= used_d;
      total_q <= total_d;
      rvalid_q <= (phase_q == PH_UPD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      value_q <= value_i;
      add_q <= add_count_i;
    end
    res_cnt_q <= res_cnt_d;
    res_hit_q <= res_hit_d;
    res_full_q <= res_full_d;
  end

  // one-hot select of the matching slot's count
  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_cnt = hit_cnt | (cell_count[i] & {DW{cell_eq[i]}});
    end
  end
  assign hit = |cell_eq;

  always_comb begin
    op = smt_pkg::OP_NONE;
    used_d = used_q;
    total_d = total_q;
    res_cnt_d = res_cnt_q;
    res_hit_d = res_hit_q;
    res_full_d = res_full_q;
    if (phase_q == PH_UPD) begin
      res_cnt_d = '0;
      res_hit_d = 1'b0;
      res_full_d = 1'b0;
      case (cmd_q)
        smt_pkg::CMD_ADD: begin
          if (hit) begin
            op = smt_pkg::OP_MERGE;
            total_d = smt_pkg::sat_add(total_q, add_ext);
            res_cnt_d = smt_pkg::sat_add(hit_cnt, add_ext);
            res_hit_d = 1'b1;
          end else if (used_q == CNT_W'(MAX_ENTRIES)) begin
            res_full_d = 1'b1;
          end else begin
            op = smt_pkg::OP_INSERT;
            used_d = used_q + CNT_W'(1);
            total_d = smt_pkg::sat_add(total_q, add_ext);
            res_cnt_d = add_ext;
            res_hit_d = 1'b1;
          end
        end
        smt_pkg::CMD_REMOVE: begin
          if (hit) begin
            op = smt_pkg::OP_DELETE;
            used_d = used_q - CNT_W'(1);
            total_d = (hit_cnt > total_q) ? '0 : total_q - hit_cnt;
          end
        end
        default: begin
          res_cnt_d = hit ? hit_cnt : '0;
          res_hit_d = hit;
        end
      endcase
    end
  end

  always_comb begin
    ctrl.cmp_en = (phase_q == PH_CMP);
    ctrl.upd_en = (phase_q == PH_UPD);
    ctrl.op = op;
    ctrl.value = value_q;
    ctrl.add_cnt = add_q;
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic                 left_lt;
    logic signed [DW-1:0] left_key, right_key;
    logic [DW-1:0]        left_count, right_count;

    assign cell_valid[g] = (CNT_W'(g) < used_q);

    if (g == 0) begin : g_first
      assign left_lt = 1'b1;
      assign left_key = '0;
      assign left_count = '0;
    end else begin : g_mid
      assign left_lt = cell_lt[g-1];
      assign left_key = cell_key[g-1];
      assign left_count = cell_count[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_key = '0;
      assign right_count = '0;
    end else begin : g_inner
      assign right_key = cell_key[g+1];
      assign right_count = cell_count[g+1];
    end

    smt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .valid_i      (cell_valid[g]),
      .left_lt_i    (left_lt),
      .left_key_i   (left_key),
      .left_count_i (left_count),
      .right_key_i  (right_key),
      .right_count_i(right_count),
      .key_o        (cell_key[g]),
      .count_o      (cell_count[g]),
      .lt_o         (cell_lt[g]),
      .eq_o         (cell_eq[g])
    );
  end

  assign result_valid_o = rvalid_q;
  assign count_of_value_o = res_cnt_q;
  assign value_present_o = res_hit_q;
  assign table_full_error_o = res_full_q;
  assign item_total_o = total_q;
  assign set_empty_o = (used_q == '0);
  assign smallest_value_o = (used_q == '0) ? '0 : cell_key[0];

endmodule

// File: sv/smt_checker.sv
// Port-level checks for the sorted multiset table, bound to the top level.
module smt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              result_valid_o,
  input logic [smt_pkg::DATA_W-1:0]        count_of_value_o,
  input logic                              value_present_o,
  input logic                              set_empty_o,
  input logic                              table_full_error_o
);

  // result regs load at the end of the update phase, which follows the transfer's compare phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 result_valid_o)
    else $error("result missing after command transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 3))
    else $error("result without a command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && table_full_error_o) |-> (!value_present_o && count_of_value_o == '0))
    else $error("dropped add reports a present value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && value_present_o) |-> !set_empty_o)
    else $error("value present in an empty table");

endmodule

bind sorted_multiset_table_core smt_checker u_smt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .result_valid_o    (result_valid_o),
  .count_of_value_o  (count_of_value_o),
  .value_present_o   (value_present_o),
  .set_empty_o       (set_empty_o),
  .table_full_error_o(table_full_error_o)
);

// File: tb/sorted_multiset_table_core_test.sv
// Self-checking testbench for the sorted multiset table core: commands in, one result each.
`timescale 1ns / 1ps

typedef struct {
  logic [31:0]        occurrences;
  logic               present;
  logic [31:0]        total;
  logic signed [31:0] smallest;
  logic               empty;
  logic               full_err;
} table_result_t;

// Tracks the table contents and the results still owed by the block.
class multiset_scoreboard;
  logic signed [31:0] keys [smt_pkg::MAX_ENTRIES_DEF];
  logic [31:0]        counts [smt_pkg::MAX_ENTRIES_DEF];
  int unsigned        used;
  logic [31:0]        total;
  table_result_t      pending [$];
  int unsigned        errors;

  function new();
    used = 0;
    total = '0;
    errors = 0;
  endfunction

  function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    if (s < a) s = '1;
    return s;
  endfunction

  // Apply one transferred command to the table and queue the result it owes.
  function void note_command(logic [1:0] cmd, logic signed [31:0] v, logic [15:0] n);
    int unsigned   pos;
    int unsigned   i;
    logic          hit;
    logic [31:0]   c;
    table_result_t r;
    pos = 0;
    while (pos < used && keys[pos] < v) pos++;
    hit = (pos < used) && (keys[pos] == v);
    r.full_err = 1'b0;
    if (cmd == smt_pkg::CMD_ADD) begin
      if (hit) begin
        counts[pos] = sat_sum(counts[pos], {16'h0, n});
        total = sat_sum(total, {16'h0, n});
      end else if (used == smt_pkg::MAX_ENTRIES_DEF) begin
        r.full_err = 1'b1;
      end else begin
        for (i = used; i > pos; i--) begin
          keys[i] = keys[i-1];
          counts[i] = counts[i-1];
        end
        keys[pos] = v;
        counts[pos] = {16'h0, n};
        used++;
        total = sat_sum(total, {16'h0, n});
        hit = 1'b1;
      end
    end else if (cmd == smt_pkg::CMD_REMOVE) begin
      if (hit) begin
        c = counts[pos];
        // a saturated total can be smaller than the sum of the counts
        total = (c > total) ? '0 : total - c;
        for (i = pos; i + 1 < used; i++) begin
          keys[i] = keys[i+1];
          counts[i] = counts[i+1];
        end
        used--;
        hit = 1'b0;
      end
    end
    r.occurrences = hit ? counts[pos] : '0;
    r.present = hit;
    r.total = total;
    r.smallest = (used > 0) ? keys[0] : '0;
    r.empty = (used == 0);
    pending.push_back(r);
  endfunction

  task report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    // stay quiet after the first few dozen so a broken block cannot flood the log
    if (errors <= 40) $display("mismatch %s: got %h expected %h", field, got, want);
  endtask

  task check_result(table_result_t got);
    table_result_t want;
    if (pending.size() == 0) begin
      report("unexpected result, total", got.total, '0);
      return;
    end
    want = pending.pop_front();
    if (got.occurrences !== want.occurrences)
      report("count_of_value", got.occurrences, want.occurrences);
    if (got.present !== want.present)
      report("value_present", 32'(got.present), 32'(want.present));
    if (got.total !== want.total) report("item_total", got.total, want.total);
    if (got.smallest !== want.smallest) report("smallest_value", got.smallest, want.smallest);
    if (got.empty !== want.empty) report("set_empty", 32'(got.empty), 32'(want.empty));
    if (got.full_err !== want.full_err)
      report("table_full_error", 32'(got.full_err), 32'(want.full_err));
  endtask
endclass

module sorted_multiset_table_core_test;

  localparam logic [smt_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned POOL_SIZE = 72;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

  logic                              clk_i;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [smt_pkg::CMD_W-1:0]         command_i = smt_pkg::CMD_QUERY;
  logic signed [smt_pkg::DATA_W-1:0] value_i = '0;
  logic [smt_pkg::ADD_W-1:0]         add_count_i = '0;
  logic                              result_valid_o;
  logic [smt_pkg::DATA_W-1:0]        count_of_value_o;
  logic                              value_present_o;
  logic [smt_pkg::DATA_W-1:0]        item_total_o;
  logic signed [smt_pkg::DATA_W-1:0] smallest_value_o;
  logic                              set_empty_o;
  logic                              table_full_error_o;

  multiset_scoreboard sb = new();
  logic signed [31:0] value_pool [POOL_SIZE];

  sorted_multiset_table_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .value_i            (value_i),
    .add_count_i        (add_count_i),
    .result_valid_o     (result_valid_o),
    .count_of_value_o   (count_of_value_o),
    .value_present_o    (value_present_o),
    .item_total_o       (item_total_o),
    .smallest_value_o   (smallest_value_o),
    .set_empty_o        (set_empty_o),
    .table_full_error_o (table_full_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Results are checked before the same edge's command is noted, so the
  // oldest expectation always lines up with the result on the ports.
  always @(posedge clk_i) begin
    table_result_t got;
    if (rst_ni) begin
      if (result_valid_o) begin
        got.occurrences = count_of_value_o;
        got.present = value_present_o;
        got.total = item_total_o;
        got.smallest = smallest_value_o;
        got.empty = set_empty_o;
        got.full_err = table_full_error_o;
        sb.check_result(got);
      end
      if (start && !busy) sb.note_command(command_i, value_i, add_count_i);
    end
  end

  // Leaves start high after the transfer so back-to-back commands need no gap.
  task automatic issue_command(input logic [smt_pkg::CMD_W-1:0] cmd,
                               input logic signed [31:0] v,
                               input logic [smt_pkg::ADD_W-1:0] n);
    start <= 1'b1;
    command_i <= cmd;
    value_i <= v;
    add_count_i <= n;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    command_i <= smt_pkg::CMD_W'($urandom);
    value_i <= $urandom;
    add_count_i <= smt_pkg::ADD_W'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  // The first negedge lets the last transfer be noted before the queue is looked at.
  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned idle_pct, input int unsigned add_pct,
                              input int unsigned remove_pct);
    int unsigned               gap;
    int unsigned               r;
    logic [smt_pkg::CMD_W-1:0] cmd;
    logic signed [31:0]        v;
    repeat (PHASE_ITEMS) begin
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) hold_off(gap);
      r = $urandom_range(99);
      if (r < add_pct) cmd = smt_pkg::CMD_ADD;
      else if (r < add_pct + remove_pct) cmd = smt_pkg::CMD_REMOVE;
      else if (r < 95) cmd = smt_pkg::CMD_QUERY;
      else cmd = CMD_SPARE;
      // mostly pool values so entries get hit, merged and the table fills up
      if ($urandom_range(9) == 0) v = $urandom;
      else v = value_pool[$urandom_range(POOL_SIZE - 1)];
      issue_command(cmd, v, smt_pkg::ADD_W'($urandom));
    end
    wait_for_results();
  endtask

  initial begin
    logic signed [31:0] held [$];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, every command, extremes of the fields
    issue_command(smt_pkg::CMD_QUERY, 32'sd0, 16'h0);
    issue_command(smt_pkg::CMD_REMOVE, 32'sd7, 16'h0);
    issue_command(CMD_SPARE, MOST_NEG, 16'hffff);
    issue_command(smt_pkg::CMD_ADD, MOST_POS, 16'hffff);
    issue_command(smt_pkg::CMD_ADD, MOST_NEG, 16'h0);   // zero count still creates the entry
    issue_command(smt_pkg::CMD_ADD, 32'sd0, 16'h1);
    issue_command(smt_pkg::CMD_ADD, -32'sd1, 16'h5555);
    issue_command(smt_pkg::CMD_ADD, -32'sd1, 16'haaaa);
    issue_command(smt_pkg::CMD_ADD, 32'sh5555_5555, 16'haaaa);
    issue_command(smt_pkg::CMD_ADD, 32'shaaaa_aaaa, 16'h5555);
    issue_command(smt_pkg::CMD_QUERY, -32'sd1, 16'hffff);
    issue_command(smt_pkg::CMD_QUERY, 32'sd7, 16'h0);
    issue_command(CMD_SPARE, 32'sh5555_5555, 16'h0);
    issue_command(smt_pkg::CMD_REMOVE, 32'sd7, 16'h0);
    issue_command(smt_pkg::CMD_REMOVE, MOST_NEG, 16'h0);
    issue_command(smt_pkg::CMD_REMOVE, 32'shaaaa_aaaa, 16'h0);
    issue_command(smt_pkg::CMD_REMOVE, -32'sd1, 16'h0);
    issue_command(smt_pkg::CMD_ADD, 32'sd0, 16'hffff);
    issue_command(smt_pkg::CMD_REMOVE, MOST_POS, 16'h0);
    issue_command(smt_pkg::CMD_REMOVE, 32'sh5555_5555, 16'h0);
    issue_command(smt_pkg::CMD_REMOVE, 32'sd0, 16'h0);
    issue_command(smt_pkg::CMD_QUERY, MOST_POS, 16'h0);
    wait_for_results();

    // pool a bit larger than the table, so adds of new values hit a full table
    value_pool[0] = MOST_NEG;
    value_pool[1] = MOST_POS;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++)
      value_pool[i] = (i % 3 == 0) ? $signed(32'($urandom_range(200))) - 32'sd100 : $urandom;

    random_phase(0, 55, 20);
    random_phase(63, 55, 20);
    // receiver cannot stall; this phase runs flat out and drains the table
    random_phase(0, 25, 55);
    random_phase(36, 55, 20);

    // empty the table, then merge repeatedly into one entry and drain it again
    for (int i = 0; i < sb.used; i++) held.push_back(sb.keys[i]);
    foreach (held[i]) issue_command(smt_pkg::CMD_REMOVE, held[i], 16'h0);
    issue_command(smt_pkg::CMD_ADD, 32'sd100, 16'd3);
    repeat (20) issue_command(smt_pkg::CMD_ADD, -32'sd100, 16'hffff);
    issue_command(smt_pkg::CMD_ADD, 32'sd100, 16'hffff);
    issue_command(smt_pkg::CMD_REMOVE, -32'sd100, 16'h0);
    issue_command(smt_pkg::CMD_REMOVE, 32'sd100, 16'h0);
    issue_command(smt_pkg::CMD_QUERY, 32'sd100, 16'h0);

    wait_for_results();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sorted_multiset_table_core.f
sv/smt_pkg.sv
sv/smt_cell.sv
sv/sorted_multiset_table_core.sv
sv/smt_checker.sv
tb/sorted_multiset_table_core_test.sv
